// File: sv/tfkr_pkg.sv
`timescale 1ns / 1ps

package tfkr_pkg;

  localparam int DEPTH        = 16;
  localparam int TAG_BITS     = 32;
  localparam int PAYLOAD_BITS = 32;
  localparam int ADDR_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W        = $clog2(DEPTH + 1);
  localparam int ENTRY_W      = TAG_BITS + PAYLOAD_BITS;

  // request kinds
  localparam logic [1:0] REQ_ENQ   = 2'd0;
  localparam logic [1:0] REQ_DEQ   = 2'd1;
  localparam logic [1:0] REQ_TAG   = 2'd2;
  localparam logic [1:0] REQ_FLUSH = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

// File: sv/tfkr_ram.sv
`timescale 1ns / 1ps

module tfkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/tagged_fifo_with_keyed_removal_core.sv
`timescale 1ns / 1ps
// enqueue and any request on an empty queue give their result from S_RESP, through the output register
// dequeue and dequeue-by-tag: the search reads entries in order (S_SRCH_RD, S_SRCH_CMP) until a hit,
// then closing the gap moves each younger entry down one slot (S_SHIFT_RD, S_SHIFT_WR)
// flush: one result per entry, occupancy results, each held while the output stalls; one request at a time
// rst (synchronous, active high) empties the queue; entry storage is not cleared

module tagged_fifo_with_keyed_removal_core import tfkr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // block_tag [31:0], payload_in [63:32]
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // tag_out [31:0], payload_out [63:32]
  output logic [1:0]  m_tuser,   // status [1:0]
  output logic        m_tlast    // last_of_run
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_SRCH_RD   = 8'b0000_0010,
    S_SRCH_CMP  = 8'b0000_0100,
    S_SHIFT_RD  = 8'b0000_1000,
    S_SHIFT_WR  = 8'b0001_0000,
    S_FLUSH_RD  = 8'b0010_0000,
    S_FLUSH_OUT = 8'b0100_0000,
    S_RESP      = 8'b1000_0000
  } state_t;

  state_t                  state, state_next;
  logic [OCC_W-1:0]        occ, occ_next;
  logic [ADDR_W-1:0]       idx, idx_next;
  logic [1:0]              req, req_next;
  logic [TAG_BITS-1:0]     key, key_next;
  logic [1:0]              res_status, res_status_next;
  logic [TAG_BITS-1:0]     res_tag, res_tag_next;
  logic [PAYLOAD_BITS-1:0] res_pay, res_pay_next;

  logic                    wr_en, rd_en;
  logic [ADDR_W-1:0]       wr_addr, rd_addr;
  logic [ENTRY_W-1:0]      wr_data, rd_data;
  logic [TAG_BITS-1:0]     rd_tag;
  logic [PAYLOAD_BITS-1:0] rd_pay;
  logic [OCC_W-1:0]        idx_p1;

  logic                    out_free, out_load;
  logic [1:0]              out_status;
  logic [TAG_BITS-1:0]     out_tag;
  logic [PAYLOAD_BITS-1:0] out_pay;
  logic                    out_last;

  tfkr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_tag   = rd_data[TAG_BITS-1:0];
  assign rd_pay   = rd_data[ENTRY_W-1:TAG_BITS];
  assign idx_p1   = OCC_W'(idx) + OCC_W'(1);
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next      = state;
    occ_next        = occ;
    idx_next        = idx;
    req_next        = req;
    key_next        = key;
    res_status_next = res_status;
    res_tag_next    = res_tag;
    res_pay_next    = res_pay;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = idx;
    out_load        = 1'b0;
    out_status      = res_status;
    out_tag         = res_tag;
    out_pay         = res_pay;
    out_last        = 1'b1;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          req_next     = s_tuser;
          key_next     = s_tdata[TAG_BITS-1:0];
          idx_next     = '0;
          res_tag_next = '0;
          res_pay_next = '0;
          case (s_tuser)
            REQ_ENQ: begin
              if (occ == OCC_W'(DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_addr         = occ[ADDR_W-1:0];
                wr_data         = {s_tdata[TAG_BITS +: PAYLOAD_BITS],
                                   s_tdata[TAG_BITS-1:0]};
                occ_next        = occ + OCC_W'(1);
                res_status_next = ST_OK;
              end
              state_next = S_RESP;
            end
            default: begin
              if (occ == '0) begin
                res_status_next = ST_EMPTY;
                state_next      = S_RESP;
              end else if (s_tuser == REQ_FLUSH) begin
                state_next = S_FLUSH_RD;
              end else begin
                state_next = S_SRCH_RD;
              end
            end
          endcase
        end
      end

      S_SRCH_RD: begin
        rd_en      = 1'b1;
        state_next = S_SRCH_CMP;
      end

      S_SRCH_CMP: begin
        // plain dequeue takes the oldest entry without a compare
        if (req == REQ_DEQ || rd_tag == key) begin
          res_status_next = ST_OK;
          res_tag_next    = rd_tag;
          res_pay_next    = rd_pay;
          if (idx_p1 < occ) begin
            state_next = S_SHIFT_RD;
          end else begin
            occ_next   = occ - OCC_W'(1);
            state_next = S_RESP;
          end
        end else if (idx_p1 == occ) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_RESP;
        end else begin
          idx_next   = idx + ADDR_W'(1);
          state_next = S_SRCH_RD;
        end
      end

      S_SHIFT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx_p1[ADDR_W-1:0];
        state_next = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        // move the younger neighbor down one slot to close the gap
        wr_en = 1'b1;
        if (idx_p1 + OCC_W'(1) < occ) begin
          idx_next   = idx + ADDR_W'(1);
          state_next = S_SHIFT_RD;
        end else begin
          occ_next   = occ - OCC_W'(1);
          state_next = S_RESP;
        end
      end

      S_FLUSH_RD: begin
        rd_en      = 1'b1;
        state_next = S_FLUSH_OUT;
      end

      S_FLUSH_OUT: begin
        out_status = ST_OK;
        out_tag    = rd_tag;
        out_pay    = rd_pay;
        out_last   = (idx_p1 == occ);
        if (out_free) begin
          out_load = 1'b1;
          if (idx_p1 == occ) begin
            occ_next   = '0;
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + ADDR_W'(1);
            state_next = S_FLUSH_RD;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      occ   <= occ_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    req        <= req_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_tag    <= res_tag_next;
    res_pay    <= res_pay_next;
    if (out_load) begin
      m_tuser <= out_status;
      m_tdata <= {32'(out_pay), 32'(out_tag)};
      m_tlast <= out_last;
    end
  end

endmodule

// File: tb/tagged_fifo_with_keyed_removal_core_tb.sv
`timescale 1ns / 1ps

module tagged_fifo_with_keyed_removal_core_tb;
  import tfkr_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int POOL_SIZE    = 6;

  typedef struct packed {
    logic [1:0]              status;
    logic [TAG_BITS-1:0]     tag;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    last;
  } queue_result_t;

  class tag_queue_scoreboard;
    logic [TAG_BITS-1:0]     tags [DEPTH];
    logic [PAYLOAD_BITS-1:0] payloads [DEPTH];
    int unsigned             count;
    queue_result_t           awaited [$];
    int unsigned             mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    function void expect_result(logic [1:0] st, logic [TAG_BITS-1:0] tag,
                                logic [PAYLOAD_BITS-1:0] pay, logic last);
      queue_result_t r;
      r.status  = st;
      r.tag     = tag;
      r.payload = pay;
      r.last    = last;
      awaited.push_back(r);
    endfunction

    // close the gap behind a removed entry, keeping order
    function void remove_entry(int unsigned pos);
      for (int unsigned i = pos; i + 1 < count; i++) begin
        tags[i]     = tags[i + 1];
        payloads[i] = payloads[i + 1];
      end
      count--;
    endfunction

    function void note_request(logic [1:0] req, logic [TAG_BITS-1:0] tag,
                               logic [PAYLOAD_BITS-1:0] pay);
      int unsigned pos;
      bit          hit;
      hit = 1'b0;
      pos = 0;
      if (req == REQ_ENQ) begin
        if (count >= DEPTH) begin
          expect_result(ST_FULL, '0, '0, 1'b1);
        end else begin
          tags[count]     = tag;
          payloads[count] = pay;
          count++;
          expect_result(ST_OK, '0, '0, 1'b1);
        end
      end else if (count == 0) begin
        expect_result(ST_EMPTY, '0, '0, 1'b1);
      end else if (req == REQ_DEQ) begin
        expect_result(ST_OK, tags[0], payloads[0], 1'b1);
        remove_entry(0);
      end else if (req == REQ_TAG) begin
        for (int unsigned i = 0; i < count; i++) begin
          if (!hit && tags[i] == tag) begin
            hit = 1'b1;
            pos = i;
          end
        end
        if (hit) begin
          expect_result(ST_OK, tags[pos], payloads[pos], 1'b1);
          remove_entry(pos);
        end else begin
          expect_result(ST_NOTFOUND, '0, '0, 1'b1);
        end
      end else begin
        for (int unsigned i = 0; i < count; i++)
          expect_result(ST_OK, tags[i], payloads[i], (i + 1 == count));
        count = 0;
      end
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [1:0] st, logic [TAG_BITS-1:0] tag,
                      logic [PAYLOAD_BITS-1:0] pay, logic last);
      queue_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("result with nothing outstanding", {tag, pay}, '0);
      end else begin
        want = awaited.pop_front();
        if (st !== want.status)
          report_mismatch("status", 64'(st), 64'(want.status));
        if (tag !== want.tag)
          report_mismatch("tag_out", 64'(tag), 64'(want.tag));
        if (pay !== want.payload)
          report_mismatch("payload_out", 64'(pay), 64'(want.payload));
        if (last !== want.last)
          report_mismatch("last_of_run", 64'(last), 64'(want.last));
      end
    endtask

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // block_tag [31:0], payload_in [63:32]
  logic [1:0]  s_tuser;   // req_type [1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // tag_out [31:0], payload_out [63:32]
  logic [1:0]  m_tuser;   // status [1:0]
  logic        m_tlast;

  tag_queue_scoreboard sb;
  bit                  calm;
  bit                  hold_armed;
  bit                  hold_done;
  logic [TAG_BITS-1:0] tag_pool [POOL_SIZE];

  tagged_fifo_with_keyed_removal_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #24_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // mostly tags that are already around so searches hit, sometimes anything
  function automatic logic [TAG_BITS-1:0] pick_tag(int pool_pct);
    if ($urandom_range(99) < pool_pct) return tag_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  task automatic send_request(input logic [1:0] req, input logic [TAG_BITS-1:0] tag,
                              input logic [PAYLOAD_BITS-1:0] pay);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {pay, tag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_request(s_tuser, s_tdata[TAG_BITS-1:0], s_tdata[TAG_BITS +: PAYLOAD_BITS]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[TAG_BITS-1:0], m_tdata[TAG_BITS +: PAYLOAD_BITS],
                      m_tlast);
  end

  // receiver: random back-pressure plus one long hold-off that stalls the block
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        m_tready  <= 1'b0;
        hold_done = 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(99) < 4) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(60, 20)) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(99) < 75);
      end
    end
  end

  initial begin
    logic [TAG_BITS-1:0]     dup_tag;
    logic [TAG_BITS-1:0]     tag;
    logic [PAYLOAD_BITS-1:0] pay;
    int                      enq_pct;
    int                      r;

    sb         = new();
    calm       = 1'b0;
    hold_armed = 1'b0;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= REQ_ENQ;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) tag_pool[i] = $urandom;
    dup_tag = 32'h5A5A_0001;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue answers
    send_request(REQ_DEQ, '0, '0);
    send_request(REQ_TAG, '1, '1);
    send_request(REQ_FLUSH, '0, '0);

    // fill up, with extremes and a repeated tag
    for (int k = 0; k < DEPTH; k++) begin
      tag = $urandom;
      pay = $urandom;
      if (k == 0) begin
        tag = '0;
        pay = '0;
      end else if (k == 1) begin
        tag = '1;
        pay = '1;
      end else if (k == 3 || k == 7) begin
        tag = dup_tag;
      end
      send_request(REQ_ENQ, tag, pay);
    end
    send_request(REQ_ENQ, 32'h1234_5678, '1);
    send_request(REQ_TAG, 32'h8000_0000, '0);
    send_request(REQ_TAG, dup_tag, '0);
    send_request(REQ_TAG, '1, '0);
    send_request(REQ_DEQ, '0, '0);
    send_request(REQ_FLUSH, '0, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        enq_pct = $urandom_range(80, 30);
        calm    = ($urandom_range(3) == 0);
      end
      if (n == 60) hold_armed = 1'b1;
      if ($urandom_range(99) < enq_pct) begin
        send_request(REQ_ENQ, pick_tag(85), $urandom);
      end else begin
        r = $urandom_range(99);
        if (r < 30)
          send_request(REQ_DEQ, $urandom, $urandom);
        else if (r < 88)
          send_request(REQ_TAG, pick_tag(75), $urandom);
        else
          send_request(REQ_FLUSH, $urandom, $urandom);
      end
    end
    s_tvalid <= 1'b0;
    calm     = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch("results never arrived", 64'(sb.pending()), 64'(0));
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/tfkr_pkg.sv
sv/tfkr_ram.sv
sv/tagged_fifo_with_keyed_removal_core.sv
tb/tagged_fifo_with_keyed_removal_core_tb.sv
